@@ hw/rtl/xmodem_sender_engine_top_defines.svh @@
// assertion macros shared by the xmodem sender engine rtl
// no dependencies
`ifndef XMODEM_SENDER_ENGINE_TOP_DEFINES_SVH
`define XMODEM_SENDER_ENGINE_TOP_DEFINES_SVH
// assert that an antecedent implies a consequent on the same edge
`define XSE_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// assert that an antecedent implies a consequent on the next edge
`define XSE_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/xse_pkg.sv @@
// shared types and constants for the xmodem sender engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package xse_pkg;
    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_CAN = 8'h18;
    localparam logic [7:0] B_C   = 8'h43;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT, PH_SEND, PH_EOT, PH_DONE, PH_ABORT, PH_TIMEOUT
    } phase_t;

    typedef enum logic [2:0] {
        ST_WAITING = 3'd0, ST_SENDING = 3'd1, ST_COMPLETED = 3'd2,
        ST_ABORTED = 3'd3, ST_TIMED_OUT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_LONG = 2'd0, REG_CRC = 2'd1, REG_TIMEOUT = 2'd2, REG_TOTAL = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic       op;
        logic       rx_valid;
        logic [7:0] rx_first;
        logic [7:0] rx_second;
        logic [7:0] flash_byte;
    } in_item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        flash_take;
        logic [2:0]  status;
        logic [31:0] uploaded_bytes;
    } out_item_t;

    // one crc-16/xmodem byte update
    function automatic logic [15:0] crc_step(input logic [15:0] c0, input logic [7:0] b);
        logic [15:0] c;
        c = c0 ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/xse_stream_if.sv @@
// valid/ready channel carrying one item of payload type
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface xse_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/xse_ram.sv @@
// generic single-port write, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module xse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/xmodem_sender_engine_top.sv @@
// xmodem sender engine top level: control, payload ram, apb registers
// depends on xse_pkg, xse_stream_if, xse_ram and the defines header
//
// usage: in_ch carries poll items (op=0, optional two-byte reply) and
// transmit-slot items (op=1); each accepted item yields exactly one result
// item on out_ch with tx byte, last flag, flash take, status and the upload
// count. the engine takes one item per cycle while the skid slot is free;
// each result is registered in an output register with a single skid slot,
// so input stays ready while one result waits. resend payload comes from a
// 1-entry-per-byte ram with a registered read: the read address for the
// next frame position is issued one item ahead, so the read data is ready
// when the byte is needed without stalling.
// if the receiver stalls, at most one further item is taken into the skid
// slot and then in_ch.ready drops until out_ch drains.
// reset (rst_n low, asynchronous) returns the engine to waiting for the first
// trigger with default registers; only reset restarts a finished transfer.
// the apb port writes long_packets, use_crc, timeout_polls, total_length at
// byte addresses 0, 4, 8, 12.
`timescale 1ns / 1ps
`default_nettype none
`include "xmodem_sender_engine_top_defines.svh"
module xmodem_sender_engine_top #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    xse_stream_if.sink       in_ch,
    xse_stream_if.source     out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import xse_pkg::*;
    localparam int AW = $clog2(MAX_PAYLOAD);

    logic        long_reg, crc_reg;
    logic [7:0]  tmo_reg;
    logic [31:0] total_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  seq_sent_reg, seq_sent_next, seq_acked_reg, seq_acked_next;
    logic [23:0] wrap_reg, wrap_next;
    logic [7:0]  poll_reg, poll_next;
    logic [31:0] left_reg, left_next;
    logic [10:0] pos_reg, pos_next;
    logic [10:0] fill_reg, fill_next;
    logic [15:0] chk_reg, chk_next;
    logic [31:0] up_reg, up_next;
    logic        newf_reg, newf_next;

    out_item_t   res;
    out_item_t   out_reg, skid_reg;
    logic        out_v_reg, skid_v_reg;
    logic        acc;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]  rdata;

    // apb register file
    assign pready = 1'b1;
    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_LONG:    prdata = {31'd0, long_reg};
            REG_CRC:     prdata = {31'd0, crc_reg};
            REG_TIMEOUT: prdata = {24'd0, tmo_reg};
            REG_TOTAL:   prdata = total_reg;
            default:     prdata = 32'd0;
        endcase
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_reg <= 1'b0; crc_reg <= 1'b1; tmo_reg <= 8'd20; total_reg <= 32'd0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_LONG:    long_reg <= pwdata[0];
                REG_CRC:     crc_reg <= pwdata[0];
                REG_TIMEOUT: tmo_reg <= pwdata[7:0];
                REG_TOTAL:   total_reg <= pwdata;
                default:     ;
            endcase
        end
    end

    // packet length, capped at the store depth
    logic [10:0] plen;
    always_comb
    begin
        plen = long_reg ? 11'd1024 : 11'd128;
        if ({1'b0, plen} > 12'(MAX_PAYLOAD))
        begin
            plen = 11'(MAX_PAYLOAD);
        end
    end

    // payload ram; read address tracks the next position
    xse_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(in_ch.data.flash_byte),
        .raddr(raddr), .rdata(rdata)
    );
    // ram output is valid for payload index pos_reg-3 when prefetched
    always_comb
    begin
        logic [10:0] np;
        np = acc ? pos_next : pos_reg;
        raddr = AW'(np - 11'd3);
    end

    // engine next state and result
    always_comb
    begin
        in_item_t it;
        logic [10:0] p;
        logic [7:0]  b;
        logic        last;
        logic [31:0] n;
        logic        trig;
        it = in_ch.data;
        p = pos_reg - 11'd3;
        b = 8'h00; last = 1'b0; n = 32'd0; trig = 1'b0;
        phase_next = phase_reg; seq_sent_next = seq_sent_reg;
        seq_acked_next = seq_acked_reg; wrap_next = wrap_reg; poll_next = poll_reg;
        left_next = left_reg; pos_next = pos_reg; fill_next = fill_reg;
        chk_next = chk_reg; up_next = up_reg; newf_next = newf_reg;
        we = 1'b0; waddr = AW'(p);
        res = '0;
        if (!it.op)
        begin
            if (phase_reg == PH_IDLE || phase_reg == PH_WAIT)
            begin
                poll_next = poll_reg + 8'd1;
                if (poll_next >= tmo_reg)
                begin
                    phase_next = PH_TIMEOUT;
                end
                else if (it.rx_valid)
                begin
                    if (it.rx_first == B_ACK)
                    begin
                        if (seq_sent_reg == seq_acked_reg + 8'd1)
                        begin
                            seq_acked_next = seq_sent_reg;
                            if (seq_sent_reg == 8'd0)
                            begin
                                wrap_next = wrap_reg + 24'd1;
                            end
                            trig = 1'b1;
                        end
                    end
                    else if (it.rx_first == B_NAK)
                    begin
                        trig = 1'b1;
                    end
                    else if (it.rx_first == B_CAN)
                    begin
                        if (it.rx_second == B_CAN)
                        begin
                            phase_next = PH_ABORT;
                        end
                    end
                    else if (it.rx_first == B_C)
                    begin
                        trig = (seq_acked_reg == 8'd0) && (wrap_reg == 24'd0);
                    end
                end
                if (trig)
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        left_next = total_reg;
                    end
                    if (seq_sent_reg == seq_acked_next)
                    begin
                        seq_sent_next = seq_sent_reg + 8'd1;
                        if (left_next != 32'd0)
                        begin
                            n = (left_next < {21'd0, plen}) ? left_next : {21'd0, plen};
                            left_next = left_next - n;
                            fill_next = n[10:0];
                            newf_next = 1'b1;
                            phase_next = PH_SEND;
                        end
                        else
                        begin
                            phase_next = PH_EOT;
                        end
                    end
                    else
                    begin
                        newf_next = 1'b0;
                        phase_next = PH_SEND;
                    end
                    pos_next = 11'd0;
                    chk_next = 16'd0;
                end
            end
        end
        else if (phase_reg == PH_EOT)
        begin
            res.tx_valid = 1'b1; res.tx_byte = B_EOT; res.tx_last = 1'b1;
            phase_next = PH_DONE;
        end
        else if (phase_reg == PH_SEND)
        begin
            res.tx_valid = 1'b1;
            if (pos_reg == 11'd0)
            begin
                chk_next = 16'd0;
                b = long_reg ? B_STX : B_SOH;
            end
            else if (pos_reg == 11'd1)
            begin
                b = seq_sent_reg;
            end
            else if (pos_reg == 11'd2)
            begin
                b = ~seq_sent_reg;
            end
            else if ({1'b0, pos_reg} < 12'd3 + {1'b0, plen})
            begin
                if (p < fill_reg)
                begin
                    if (newf_reg)
                    begin
                        b = it.flash_byte; we = 1'b1; res.flash_take = 1'b1;
                    end
                    else
                    begin
                        b = rdata;
                    end
                end
                else
                begin
                    b = 8'hff;
                end
                chk_next = crc_reg ? crc_step(chk_reg, b) : {8'h00, chk_reg[7:0] + b};
            end
            else if (crc_reg && ({1'b0, pos_reg} == 12'd3 + {1'b0, plen}))
            begin
                b = chk_reg[15:8];
            end
            else
            begin
                last = 1'b1;
                b = chk_reg[7:0];
            end
            res.tx_byte = b; res.tx_last = last;
            if (last)
            begin
                phase_next = PH_WAIT; poll_next = 8'd0; pos_next = 11'd0;
                up_next = up_reg + {21'd0, plen};
            end
            else
            begin
                pos_next = pos_reg + 11'd1;
            end
        end
        case (phase_next)
            PH_SEND, PH_EOT: res.status = ST_SENDING;
            PH_DONE:         res.status = ST_COMPLETED;
            PH_ABORT:        res.status = ST_ABORTED;
            PH_TIMEOUT:      res.status = ST_TIMED_OUT;
            default:         res.status = ST_WAITING;
        endcase
        res.uploaded_bytes = up_next;
        if (!acc)
        begin
            we = 1'b0;
        end
    end

    // handshake with one skid slot behind the output register
    assign in_ch.ready = !skid_v_reg;
    assign acc = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_v_reg;
    assign out_ch.data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; seq_sent_reg <= '0; seq_acked_reg <= '0;
            wrap_reg <= '0; poll_reg <= '0; left_reg <= '0; pos_reg <= '0;
            fill_reg <= '0; chk_reg <= '0; up_reg <= '0; newf_reg <= 1'b1;
            out_v_reg <= 1'b0; skid_v_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                phase_reg <= phase_next; seq_sent_reg <= seq_sent_next;
                seq_acked_reg <= seq_acked_next; wrap_reg <= wrap_next;
                poll_reg <= poll_next; left_reg <= left_next; pos_reg <= pos_next;
                fill_reg <= fill_next; chk_reg <= chk_next; up_reg <= up_next;
                newf_reg <= newf_next;
            end
            if (!out_v_reg || out_ch.ready)
            begin
                if (skid_v_reg)
                begin
                    out_v_reg <= 1'b1; skid_v_reg <= acc;
                end
                else
                begin
                    out_v_reg <= acc;
                end
            end
            else if (acc)
            begin
                skid_v_reg <= 1'b1;
            end
        end
    end
    // output payload registers
    always_ff @(posedge clk)
    begin
        if (!out_v_reg || out_ch.ready)
        begin
            if (skid_v_reg)
            begin
                out_reg <= skid_reg;
                if (acc)
                begin
                    skid_reg <= res;
                end
            end
            else if (acc)
            begin
                out_reg <= res;
            end
        end
        else if (acc)
        begin
            skid_reg <= res;
        end
    end

    `XSE_ASSERT_IMP(a_skid_implies_out, clk, rst_n, skid_v_reg, out_v_reg)
    `XSE_ASSERT_NEXT(a_done_stays, clk, rst_n, phase_reg == PH_DONE, phase_reg == PH_DONE)
    `XSE_ASSERT_IMP(a_take_only_new, clk, rst_n, acc && res.flash_take, newf_reg)
endmodule
`default_nettype wire

@@ bench/xmodem_sender_engine_top_test.sv @@
// self-checking bench for the xmodem sender engine: polls and transmit slots
// drive an upload to completion, abort or timeout; results are checked against an in-bench engine model
// depends on xse_pkg, xse_stream_if and xmodem_sender_engine_top
`timescale 1ns / 1ps
module xmodem_sender_engine_top_test;
    import xse_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    xse_stream_if #(.T(in_item_t))  in_if ();
    xse_stream_if #(.T(out_item_t)) out_if ();

    xmodem_sender_engine_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // engine model state and register copies
    logic        cfg_long;
    logic        cfg_crc;
    logic [7:0]  cfg_polls;
    logic [31:0] cfg_total;
    phase_t      eng_phase;
    logic [7:0]  blk_sent;
    logic [7:0]  blk_acked;
    logic [23:0] wraps;
    logic [7:0]  poll_cnt;
    logic [31:0] left_bytes;
    int          pos;
    int          fill;
    logic [15:0] chk;
    logic [31:0] upl_cnt;
    logic        fresh;
    logic [7:0]  frame_ram [0:1023];

    in_item_t    pending_items [$];
    out_item_t   expected_results [$];
    int          errs;
    int          items_in;
    int          results_out;
    int          frames_done;
    int          idle_mode;
    int          hold_cycles;
    logic        hold_req;
    logic        took;
    logic        busy;
    in_item_t    cur;

    function automatic int payload_len();
        return cfg_long ? 1024 : 128;
    endfunction

    // fold one payload byte into the running check
    function automatic void fold_check(logic [7:0] b);
        logic [15:0] c;
        if (cfg_crc)
        begin
            c = chk ^ {b, 8'h00};
            for (int k = 0; k < 8; k++)
            begin
                if (c[15])
                    c = (c << 1) ^ 16'h1021;
                else
                    c = c << 1;
            end
            chk = c;
        end
        else
        begin
            chk = {8'h00, chk[7:0] + b};
        end
    endfunction

    // start of a new frame or a resend of the stored one
    function automatic void start_frame();
        int n;
        if (eng_phase == PH_IDLE)
            left_bytes = cfg_total;
        if (blk_sent == blk_acked)
        begin
            blk_sent = blk_sent + 8'd1;
            if (left_bytes != 0)
            begin
                n = payload_len();
                if (left_bytes < n)
                    n = left_bytes;
                left_bytes = left_bytes - n;
                fill = n;
                fresh = 1'b1;
                eng_phase = PH_SEND;
            end
            else
            begin
                eng_phase = PH_EOT;
            end
        end
        else
        begin
            fresh = 1'b0;
            eng_phase = PH_SEND;
        end
        pos = 0;
        chk = 16'h0000;
    endfunction

    function automatic void take_poll(in_item_t it);
        poll_cnt = poll_cnt + 8'd1;
        if (poll_cnt >= cfg_polls)
        begin
            eng_phase = PH_TIMEOUT;
            return;
        end
        if (!it.rx_valid)
            return;
        if (it.rx_first == B_ACK)
        begin
            if (blk_sent == blk_acked + 8'd1)
            begin
                blk_acked = blk_sent;
                if (blk_acked == 8'd0)
                    wraps = wraps + 24'd1;
                start_frame();
            end
        end
        else if (it.rx_first == B_NAK)
        begin
            start_frame();
        end
        else if (it.rx_first == B_CAN)
        begin
            if (it.rx_second == B_CAN)
                eng_phase = PH_ABORT;
        end
        else if (it.rx_first == B_C)
        begin
            if (blk_acked == 8'd0 && wraps == 24'd0)
                start_frame();
        end
    endfunction

    // expected result for one accepted item
    function automatic out_item_t predict_result(in_item_t it);
        out_item_t r;
        int        plen;
        int        p;
        logic [7:0] b;
        r = '0;
        plen = payload_len();
        if (!it.op)
        begin
            if (eng_phase == PH_IDLE || eng_phase == PH_WAIT)
                take_poll(it);
        end
        else if (eng_phase == PH_EOT)
        begin
            r.tx_valid = 1'b1;
            r.tx_byte = B_EOT;
            r.tx_last = 1'b1;
            eng_phase = PH_DONE;
        end
        else if (eng_phase == PH_SEND)
        begin
            r.tx_valid = 1'b1;
            if (pos == 0)
            begin
                chk = 16'h0000;
                r.tx_byte = cfg_long ? B_STX : B_SOH;
            end
            else if (pos == 1)
                r.tx_byte = blk_sent;
            else if (pos == 2)
                r.tx_byte = ~blk_sent;
            else if (pos < 3 + plen)
            begin
                p = pos - 3;
                if (p < fill)
                begin
                    if (fresh)
                    begin
                        b = it.flash_byte;
                        frame_ram[p] = b;
                        r.flash_take = 1'b1;
                    end
                    else
                        b = frame_ram[p];
                end
                else
                    b = 8'hff;
                fold_check(b);
                r.tx_byte = b;
            end
            else if (cfg_crc && pos == 3 + plen)
                r.tx_byte = chk[15:8];
            else
            begin
                r.tx_last = 1'b1;
                r.tx_byte = chk[7:0];
            end
            if (r.tx_last)
            begin
                eng_phase = PH_WAIT;
                poll_cnt = 8'd0;
                pos = 0;
                upl_cnt = upl_cnt + plen;
            end
            else
                pos = (pos + 1) & 16'h07ff;
        end
        case (eng_phase)
            PH_SEND, PH_EOT: r.status = ST_SENDING;
            PH_DONE: r.status = ST_COMPLETED;
            PH_ABORT: r.status = ST_ABORTED;
            PH_TIMEOUT: r.status = ST_TIMED_OUT;
            default: r.status = ST_WAITING;
        endcase
        r.uploaded_bytes = upl_cnt;
        return r;
    endfunction

    task automatic report_err(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0h, expected %0h (result %0d)",
                 what, got, want, results_out);
        errs++;
    endtask

    // monitor: check results, then predict for the item taken this edge
    always @(posedge clk)
    begin
        out_item_t g;
        out_item_t w;
        if (rst_n)
        begin
            if (out_if.valid && out_if.ready)
            begin
                g = out_if.data;
                if (expected_results.size() == 0)
                    report_err("unexpected result", 32'd1, 32'd0);
                else
                begin
                    w = expected_results.pop_front();
                    if (g.tx_valid !== w.tx_valid)
                        report_err("tx_valid", 32'(g.tx_valid), 32'(w.tx_valid));
                    if (g.tx_byte !== w.tx_byte)
                        report_err("tx_byte", 32'(g.tx_byte), 32'(w.tx_byte));
                    if (g.tx_last !== w.tx_last)
                        report_err("tx_last", 32'(g.tx_last), 32'(w.tx_last));
                    if (g.flash_take !== w.flash_take)
                        report_err("flash_take", 32'(g.flash_take), 32'(w.flash_take));
                    if (g.status !== w.status)
                        report_err("status", 32'(g.status), 32'(w.status));
                    if (g.uploaded_bytes !== w.uploaded_bytes)
                        report_err("uploaded_bytes", g.uploaded_bytes, w.uploaded_bytes);
                end
                results_out++;
            end
            if (in_if.valid && in_if.ready)
            begin
                expected_results.push_back(predict_result(in_if.data));
                items_in++;
                took = 1'b1;
            end
        end
    end

    // driver: offer pending items with random gaps
    always @(negedge clk)
    begin
        if (took)
        begin
            busy = 1'b0;
            took = 1'b0;
        end
        if (!busy && rst_n && pending_items.size() > 0 &&
            (idle_mode == 2 || $urandom_range(99) >= (idle_mode == 0 ? 34 : 78)))
        begin
            cur = pending_items.pop_front();
            busy = 1'b1;
        end
        in_if.valid <= busy;
        in_if.data <= cur;
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cycles = 300;
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_if.ready <= 1'b0;
        end
        else
            out_if.ready <= (idle_mode == 2) ||
                            ($urandom_range(99) >= (idle_mode == 0 ? 78 : 34));
    end

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        logic [31:0] want;
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_LONG: cfg_long = val[0];
            REG_CRC: cfg_crc = val[0];
            REG_TIMEOUT: cfg_polls = val[7:0];
            default: cfg_total = val;
        endcase
        // read back the register just written
        case (idx)
            REG_LONG: want = {31'd0, val[0]};
            REG_CRC: want = {31'd0, val[0]};
            REG_TIMEOUT: want = {24'd0, val[7:0]};
            default: want = val;
        endcase
        if (prdata !== want || pready !== 1'b1)
            report_err("register readback", prdata, want);
    endtask

    task automatic push_item(logic op, logic rxv, logic [7:0] r1, logic [7:0] r2);
        in_item_t it;
        it.op = op;
        it.rx_valid = rxv;
        it.rx_first = r1;
        it.rx_second = r2;
        it.flash_byte = 8'($urandom_range(255));
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || busy || expected_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // extra reply: junk, lone cancel, late 'C', or ack naming the wrong block
    task automatic push_noise_poll();
        case ($urandom_range(3))
            0: push_item(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            1: push_item(1'b0, 1'b1, B_CAN, 8'($urandom_range(23)));
            2: push_item(1'b0, 1'b1, B_C, 8'($urandom_range(255)));
            default: push_item(1'b0, 1'b1, B_ACK, blk_sent + 8'd2);
        endcase
    endtask

    // stimulus
    initial
    begin
        int end_kind;
        int n;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        cur = '0;
        busy = 1'b0;
        took = 1'b0;
        hold_req = 1'b0;
        hold_cycles = 0;
        idle_mode = 0;
        errs = 0;
        items_in = 0;
        results_out = 0;
        frames_done = 0;
        cfg_long = 1'b0;
        cfg_crc = 1'b1;
        cfg_polls = 8'd20;
        cfg_total = 32'd0;
        eng_phase = PH_IDLE;
        blk_sent = 8'd0;
        blk_acked = 8'd0;
        wraps = 24'd0;
        poll_cnt = 8'd0;
        left_bytes = 32'd0;
        pos = 0;
        fill = 0;
        chk = 16'h0000;
        upl_cnt = 32'd0;
        fresh = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // registers through their extremes, then the real settings
        reg_write(REG_LONG, 32'd1);
        reg_write(REG_CRC, 32'd0);
        reg_write(REG_TIMEOUT, 32'd255);
        reg_write(REG_TOTAL, 32'hffff_ffff);
        reg_write(REG_TOTAL, 32'd128 * 7 + 32'd1024 + 32'd37);
        reg_write(REG_LONG, 32'd0);
        reg_write(REG_CRC, 32'd1);

        // directed: ignored items before start, then 'C' starts
        push_item(1'b0, 1'b0, 8'h00, 8'h00);
        push_item(1'b0, 1'b1, 8'hff, 8'hff);
        push_item(1'b0, 1'b1, B_ACK, 8'h00);
        push_item(1'b1, 1'b0, 8'h00, 8'h00);
        push_item(1'b0, 1'b1, B_CAN, 8'h00);
        push_item(1'b0, 1'b0, B_C, 8'h00);
        push_item(1'b0, 1'b1, 8'h00, B_CAN);
        push_item(1'b0, 1'b1, B_C, 8'hff);
        push_item(1'b0, 1'b1, B_NAK, 8'h00);
        drain();

        end_kind = $urandom_range(2);
        while (eng_phase != PH_DONE && eng_phase != PH_ABORT &&
               eng_phase != PH_TIMEOUT)
        begin
            idle_mode = (items_in < 650) ? 0 : (items_in < 1300) ? 1 : 2;
            if (eng_phase == PH_SEND || eng_phase == PH_EOT)
            begin
                n = (eng_phase == PH_EOT) ? 1 : 3 + payload_len() + (cfg_crc ? 2 : 1);
                if (cfg_long)
                    hold_req = 1'b1;
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(60) == 0)
                        push_noise_poll();
                    push_item(1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
                end
                drain();
                frames_done++;
            end
            else
            begin
                // waiting: settings may change here, then a reply
                if (frames_done == 6 && end_kind == 1)
                    push_item(1'b0, 1'b1, B_CAN, B_CAN);
                else if (frames_done == 6 && end_kind == 2)
                begin
                    reg_write(REG_TIMEOUT, 32'd1);
                    push_item(1'b0, 1'b1, B_ACK, blk_sent);
                end
                else
                begin
                    if ($urandom_range(3) == 0)
                        reg_write(REG_CRC, $urandom_range(1));
                    if ($urandom_range(3) == 0)
                        reg_write(REG_TIMEOUT, $urandom_range(12, 255));
                    reg_write(REG_LONG, (frames_done == 3) ? 32'd1 : 32'd0);
                    for (int i = $urandom_range(2); i > 0; i--)
                        push_noise_poll();
                    if ($urandom_range(4) == 0 && !cfg_long)
                        push_item(1'b0, 1'b1, B_NAK, 8'($urandom_range(255)));
                    else
                        push_item(1'b0, 1'b1, B_ACK, blk_sent);
                end
                drain();
            end
        end

        // everything after the end is ignored
        for (int i = 0; i < 12; i++)
            push_item(1'($urandom_range(1)), 1'b1, (i % 2) ? B_NAK : B_C, B_CAN);
        drain();
        repeat (10) @(posedge clk);

        $display("%0d items in, %0d results, %0d frames, final status %0d",
                 items_in, results_out, frames_done, eng_phase);
        if (errs == 0)
            $display("xmodem_sender_engine_top_test passed");
        else
            $display("xmodem_sender_engine_top_test failed");
        $finish;
    end

    // run limit
    initial
    begin
        #800000;
        $display("xmodem_sender_engine_top_test failed");
        $finish;
    end
endmodule
